>>> hdl/multi_channel_timer_bank_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timer bank
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_TIMER_BANK_TOP_MACROS_SVH
`define MULTI_CHANNEL_TIMER_BANK_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MCTB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define MCTB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/mctb_pkg.sv
// ----------------------------------------------------------------------------
// mctb_pkg
// Types, codes and sizes shared by the timer bank modules.
// ----------------------------------------------------------------------------
package mctb_pkg;

	localparam int CHANNELS    = 8;
	localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MAX_RESULTS = 8;
	localparam int EV_W        = $clog2(MAX_RESULTS + 1);

	localparam int ACT_W  = 4;
	localparam int CHAN_W = 8;
	localparam int VAL_W  = 32;

	localparam logic [ACT_W-1:0] ACT_TICK      = 4'd0;
	localparam logic [ACT_W-1:0] ACT_SET_TIME  = 4'd1;
	localparam logic [ACT_W-1:0] ACT_START     = 4'd2;
	localparam logic [ACT_W-1:0] ACT_STOP      = 4'd3;
	localparam logic [ACT_W-1:0] ACT_RESET     = 4'd4;
	localparam logic [ACT_W-1:0] ACT_GET_TIME  = 4'd5;
	localparam logic [ACT_W-1:0] ACT_STOPWATCH = 4'd6;
	localparam logic [ACT_W-1:0] ACT_COUNTDOWN = 4'd7;
	localparam logic [ACT_W-1:0] ACT_EVENT_ON  = 4'd8;
	localparam logic [ACT_W-1:0] ACT_EVENT_OFF = 4'd9;

	localparam logic KIND_REPLY = 1'b0;
	localparam logic KIND_EVENT = 1'b1;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [CHAN_W-1:0] channel;
		logic [VAL_W-1:0]  value;
		logic              reload_on;
	} cmd_t;

	typedef struct packed {
		logic              kind;
		logic [CHAN_W-1:0] source_channel;
		logic              ok;
		logic [VAL_W-1:0]  count_value;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic [VAL_W-1:0] count;
		logic [VAL_W-1:0] reload;
		logic             running;
		logic             upcount;
		logic             ev_en;
	} entry_t;

	typedef struct packed {
		logic            rd_en;
		logic [CH_W-1:0] rd_addr;
		logic            wr_en;
		logic [CH_W-1:0] wr_addr;
		entry_t          wr_data;
	} mem_req_t;

endpackage

>>> hdl/multi_channel_timer_bank_top.sv
// ----------------------------------------------------------------------------
// multi_channel_timer_bank_top
// Bank of countdown / stopwatch timers with per-channel expiry events.
//
//   port        dir  handshake                 payload
//   cmd         in   start & !busy             mctb_pkg::cmd_t
//   rsp         out  rsp_strobe, one cycle     mctb_pkg::rsp_t
//
// A command runs as a memory read, then modify, write back and reply.
// A tick reads one channel per cycle through the single read port of the
// state memory, then a flush state sends the last pending event.
// Reset clears all channels at once through per-entry valid bits.
// Results cannot be held off; busy stays high until the last one is out.
// ----------------------------------------------------------------------------
module multi_channel_timer_bank_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  mctb_pkg::cmd_t cmd,
	output logic           rsp_strobe,
	output mctb_pkg::rsp_t rsp
);

	mctb_pkg::mem_req_t req;
	mctb_pkg::entry_t   rd_data;

	mctb_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	mctb_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.busy       (busy),
		.rsp_strobe (rsp_strobe),
		.rsp        (rsp),
		.req        (req),
		.rd_data    (rd_data)
	);

endmodule

>>> hdl/mctb_store.sv
// ----------------------------------------------------------------------------
// mctb_store
// Channel state memory, one entry per channel, registered read.
// Entries never written since reset read as all zero.
// ----------------------------------------------------------------------------
module mctb_store (
	input  logic              clk,
	input  logic              arst_n,
	input  mctb_pkg::mem_req_t req,
	output mctb_pkg::entry_t   rd_data
);

	mctb_pkg::entry_t mem [mctb_pkg::CHANNELS];
	mctb_pkg::entry_t rd_data_q;
	logic [mctb_pkg::CHANNELS-1:0] vld_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

>>> hdl/mctb_engine.sv
// ----------------------------------------------------------------------------
// mctb_engine
// Command sequencer: read-modify-write of one channel per command, and a
// sweep over all channels for a tick with expiry event reporting.
// ----------------------------------------------------------------------------
module mctb_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  mctb_pkg::cmd_t     cmd,
	output logic               busy,
	output logic               rsp_strobe,
	output mctb_pkg::rsp_t     rsp,
	output mctb_pkg::mem_req_t req,
	input  mctb_pkg::entry_t   rd_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CMD   = 2'd1;
	localparam logic [1:0] ST_TICK  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0] state_q, state_d;
	mctb_pkg::cmd_t cmd_q;
	logic [mctb_pkg::CH_W-1:0] idx_s1, idx_d;
	logic [mctb_pkg::CH_W-1:0] pend_ch_q, pend_ch_d;
	logic pend_vld_q, pend_vld_d;
	logic [mctb_pkg::EV_W-1:0] ev_cnt_q, ev_cnt_d;

	mctb_pkg::entry_t upd;
	logic err;
	logic ok;
	logic [mctb_pkg::VAL_W-1:0] cv;
	logic [mctb_pkg::VAL_W-1:0] dec;
	logic fire;

	assign busy = (state_q != ST_IDLE);
	assign dec  = rd_data.count - 32'd1;

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_s1;
		pend_ch_d  = pend_ch_q;
		pend_vld_d = pend_vld_q;
		ev_cnt_d   = ev_cnt_q;
		req        = '0;
		rsp        = '0;
		rsp_strobe = 1'b0;
		upd        = rd_data;
		err        = 1'b0;
		ok         = 1'b1;
		cv         = '0;
		fire       = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					req.rd_en = 1'b1;
					idx_d      = '0;
					pend_vld_d = 1'b0;
					ev_cnt_d   = '0;
					if (cmd.action == mctb_pkg::ACT_TICK) begin
						req.rd_addr = '0;
						state_d     = ST_TICK;
					end else begin
						req.rd_addr = cmd.channel[mctb_pkg::CH_W-1:0];
						state_d     = ST_CMD;
					end
				end
			end
			ST_CMD: begin
				err = (cmd_q.channel >= mctb_pkg::CHAN_W'(mctb_pkg::CHANNELS))
					|| (cmd_q.action > mctb_pkg::ACT_EVENT_OFF);
				unique case (cmd_q.action)
					mctb_pkg::ACT_SET_TIME: begin
						upd.count  = cmd_q.value;
						upd.reload = cmd_q.reload_on ? cmd_q.value : '0;
					end
					mctb_pkg::ACT_START: begin
						if (!rd_data.running) begin
							if (!rd_data.upcount && rd_data.count == '0) begin
								ok = 1'b0;
							end else begin
								upd.running = 1'b1;
							end
						end
					end
					mctb_pkg::ACT_STOP:      upd.running = 1'b0;
					mctb_pkg::ACT_RESET:     upd.count   = '0;
					mctb_pkg::ACT_GET_TIME:  cv          = rd_data.count;
					mctb_pkg::ACT_STOPWATCH: upd.upcount = 1'b1;
					mctb_pkg::ACT_COUNTDOWN: upd.upcount = 1'b0;
					mctb_pkg::ACT_EVENT_ON:  upd.ev_en   = 1'b1;
					mctb_pkg::ACT_EVENT_OFF: upd.ev_en   = 1'b0;
					default: ;
				endcase
				if (err) begin
					ok = 1'b0;
					cv = '0;
				end
				req.wr_en   = !err;
				req.wr_addr = cmd_q.channel[mctb_pkg::CH_W-1:0];
				req.wr_data = upd;
				rsp_strobe         = 1'b1;
				rsp.kind           = mctb_pkg::KIND_REPLY;
				rsp.source_channel = cmd_q.channel;
				rsp.ok             = ok;
				rsp.count_value    = cv;
				rsp.last           = 1'b1;
				state_d            = ST_IDLE;
			end
			ST_TICK: begin
				if (rd_data.running) begin
					if (rd_data.upcount) begin
						upd.count = rd_data.count + 32'd1;
					end else begin
						upd.count = dec;
						if (dec == '0) begin
							fire = rd_data.ev_en
								&& (ev_cnt_q < mctb_pkg::EV_W'(mctb_pkg::MAX_RESULTS));
							if (rd_data.reload != '0) begin
								upd.count = rd_data.reload;
							end else begin
								upd.running = 1'b0;
							end
						end
					end
				end
				req.wr_en   = rd_data.running;
				req.wr_addr = idx_s1;
				req.wr_data = upd;
				// hold the newest event back until the next one shows whether it is final
				if (fire) begin
					if (pend_vld_q) begin
						rsp_strobe         = 1'b1;
						rsp.kind           = mctb_pkg::KIND_EVENT;
						rsp.source_channel = mctb_pkg::CHAN_W'(pend_ch_q);
						rsp.ok             = 1'b1;
						rsp.last           = 1'b0;
					end
					pend_vld_d = 1'b1;
					pend_ch_d  = idx_s1;
					ev_cnt_d   = ev_cnt_q + 1'b1;
				end
				if (idx_s1 == mctb_pkg::CH_W'(mctb_pkg::CHANNELS - 1)) begin
					state_d = ST_FLUSH;
				end else begin
					idx_d       = idx_s1 + 1'b1;
					req.rd_en   = 1'b1;
					req.rd_addr = idx_s1 + 1'b1;
				end
			end
			ST_FLUSH: begin
				if (pend_vld_q) begin
					rsp_strobe         = 1'b1;
					rsp.kind           = mctb_pkg::KIND_EVENT;
					rsp.source_channel = mctb_pkg::CHAN_W'(pend_ch_q);
					rsp.ok             = 1'b1;
					rsp.last           = 1'b1;
				end
				pend_vld_d = 1'b0;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_s1     <= '0;
			pend_vld_q <= 1'b0;
			ev_cnt_q   <= '0;
		end else begin
			state_q    <= state_d;
			idx_s1     <= idx_d;
			pend_vld_q <= pend_vld_d;
			ev_cnt_q   <= ev_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_ch_q <= pend_ch_d;
		if (start && !busy) begin
			cmd_q <= cmd;
		end
	end

`include "multi_channel_timer_bank_top_macros.svh"

	`MCTB_ASSERT_NOW(a_strobe_busy, rsp_strobe, busy, "result outside an operation")
	`MCTB_ASSERT_NEXT(a_cmd_reply, start && !busy && cmd.action != mctb_pkg::ACT_TICK, rsp_strobe && rsp.last && rsp.kind == mctb_pkg::KIND_REPLY, "command reply missing")
	`MCTB_ASSERT_NOW(a_event_form, rsp_strobe && rsp.kind == mctb_pkg::KIND_EVENT, rsp.ok && rsp.count_value == '0, "malformed expiry event")
	`MCTB_ASSERT_NEXT(a_tick_sweep, start && !busy && cmd.action == mctb_pkg::ACT_TICK, state_q == ST_TICK && idx_s1 == '0, "tick sweep not begun")

endmodule
